// ----- hw/rtl/efp_pkg.sv -----
// shared constants and types for the escaped api frame parser
package efp_pkg;

  localparam int MAX_FRAME = 256;
  localparam int POS_W     = $clog2(MAX_FRAME + 2);
  localparam int FLEN_W    = 9;

  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] ESC_MARK   = 8'h7D;
  localparam logic [7:0] ESC_FLIP   = 8'h20;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;
  localparam int         HEAD_LEN   = 3;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_HUNT   = pos_t'(0);
  localparam pos_t POS_LEN_HI = pos_t'(1);
  localparam pos_t POS_LEN_LO = pos_t'(2);
  localparam pos_t POS_API    = pos_t'(3);
  localparam pos_t POS_DATA   = pos_t'(4);
  localparam pos_t POS_LAST   = pos_t'(MAX_FRAME + 1);

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [7:0]        byte_index;
    logic [7:0]        api_id;
    logic [FLEN_W-1:0] frame_length;
    logic [1:0]        status;
  } efp_result_t;

endpackage

// ----- hw/rtl/efp_deframer.sv -----
// frame state tracking and per-byte result decode
module efp_deframer
  import efp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output efp_result_t res
);

  pos_t        pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  api_r, api_nxt;

  logic        restart;
  pos_t        pos_eff;
  logic [7:0]  sum_eff;
  logic        esc_eff;
  logic [7:0]  b;
  logic [7:0]  sum_add;
  logic        at_end;

  assign restart = (pos_r != POS_HUNT) && (rx_byte == START_MARK);
  assign pos_eff = restart ? POS_HUNT : pos_r;
  assign sum_eff = restart ? 8'h00 : sum_r;
  assign esc_eff = restart ? 1'b0 : esc_r;
  assign b       = esc_eff ? (rx_byte ^ ESC_FLIP) : rx_byte;
  assign sum_add = (pos_eff >= POS_API) ? (sum_eff + b) : sum_eff;
  assign at_end  = ({1'b0, len_r} + 17'(HEAD_LEN)) == 17'(pos_eff);

  always_comb begin
    pos_nxt   = pos_eff;
    sum_nxt   = sum_eff;
    esc_nxt   = 1'b0;
    len_nxt   = len_r;
    api_nxt   = api_r;
    res_valid = 1'b0;
    res       = '0;
    res.api_id = api_r;
    if ((pos_eff != POS_HUNT) && (rx_byte == ESC_MARK) && !esc_eff) begin
      esc_nxt = 1'b1;
    end else begin
      sum_nxt = sum_add;
      case (pos_eff)
        POS_HUNT: begin
          pos_nxt = (b == START_MARK) ? POS_LEN_HI : POS_HUNT;
        end
        POS_LEN_HI: begin
          len_nxt = {b, 8'h00};
          pos_nxt = POS_LEN_LO;
        end
        POS_LEN_LO: begin
          len_nxt = {len_r[15:8], b};
          pos_nxt = POS_API;
        end
        POS_API: begin
          api_nxt = b;
          pos_nxt = POS_DATA;
        end
        default: begin
          res_valid = 1'b1;
          if (pos_eff > pos_t'(MAX_FRAME)) begin
            res.kind         = KIND_END;
            res.frame_length = FLEN_W'(MAX_FRAME - 3);
            res.status       = ST_OVERFLOW;
            pos_nxt          = POS_HUNT;
            sum_nxt          = 8'h00;
          end else if (at_end) begin
            res.kind         = KIND_END;
            res.frame_length = FLEN_W'(pos_eff - POS_DATA);
            res.status       = (sum_add == SUM_GOOD) ? ST_OK : ST_CSUM;
            pos_nxt          = POS_HUNT;
            sum_nxt          = 8'h00;
          end else begin
            res.kind       = KIND_DATA;
            res.data_byte  = b;
            res.byte_index = 8'(pos_eff - POS_DATA);
            pos_nxt        = pos_eff + pos_t'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= 8'h00;
      esc_r <= 1'b0;
      len_r <= 16'h0000;
      api_r <= 8'h00;
    end else if (step) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      esc_r <= esc_nxt;
      len_r <= len_nxt;
      api_r <= api_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("position past buffer limit");

  a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && (res.kind == KIND_END) |=> (pos_r == POS_HUNT) && (sum_r == 8'h00))
    else $error("frame end did not return to hunting");

  a_data_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && (res.kind == KIND_DATA) |=> pos_r == pos_t'($past(pos_r) + pos_t'(1)))
    else $error("data beat did not advance position");

  a_esc_framed: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (pos_r != POS_HUNT))
    else $error("escape pending while hunting");

endmodule

// ----- hw/rtl/escaped_api_frame_parser_core.sv -----
// escaped api frame parser top level: input register, deframer, result register
//
// in_rx_byte carries one raw received byte per beat on a valid/ready channel.
// each accepted byte is unescaped and tracked through the frame header
// (start byte, 16-bit length, api id). every frame data byte yields one result
// beat with kind 0, the byte and its index; the checksum byte, or a byte that
// would overflow the frame buffer, yields one end beat with kind 1, the frame
// length and a status (ok, checksum failure, overflow). header bytes, escape
// bytes and bytes seen while hunting yield nothing.
// an input beat passes from the input register through the deframer into the
// result register. throughput is one byte per cycle while the result register
// is empty or out_ready is high; a stalled result register holds the flow.
// reset returns the parser to hunting for a start byte with the sum, escape
// flag, length and api id cleared, and empties both registers.
// when the receiver stalls, the result register holds its beat, the input
// register keeps one more byte, and in_ready then drops until out_ready returns.
module escaped_api_frame_parser_core
  import efp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_data_byte,
  output logic [7:0]        out_byte_index,
  output logic [7:0]        out_api_id,
  output logic [FLEN_W-1:0] out_frame_length,
  output logic [1:0]        out_status
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  efp_result_t out_res_r;

  logic        step;
  logic        res_valid;
  efp_result_t res;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  efp_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_data_byte    = out_res_r.data_byte;
  assign out_byte_index   = out_res_r.byte_index;
  assign out_api_id       = out_res_r.api_id;
  assign out_frame_length = out_res_r.frame_length;
  assign out_status       = out_res_r.status;

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_DATA) |->
      (out_res_r.frame_length == '0) && (out_res_r.status == ST_OK))
    else $error("data beat carries end fields");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == KIND_END) |->
      (out_res_r.data_byte == 8'h00) && (out_res_r.byte_index == 8'h00)
      && (out_res_r.status <= ST_OVERFLOW))
    else $error("end beat carries data fields");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !step)
    else $error("deframer advanced while result stalled");

endmodule

// ----- sim/escaped_api_frame_parser_core_tb.sv -----
// self-checking testbench for the escaped api frame parser core
`timescale 1ns / 100ps

import efp_pkg::*;

class frame_scoreboard;
  int unsigned       pos;
  logic [7:0]        run_sum;
  bit                esc_armed;
  logic [15:0]       decl_len;
  logic [7:0]        cur_api;
  efp_result_t       parsed_beats[$];
  int unsigned       errors;
  int unsigned       data_beats;
  int unsigned       ends_ok;
  int unsigned       ends_csum;
  int unsigned       ends_ovf;

  function new();
    restart();
    decl_len   = '0;
    cur_api    = '0;
    errors     = 0;
    data_beats = 0;
    ends_ok    = 0;
    ends_csum  = 0;
    ends_ovf   = 0;
  endfunction

  function void restart();
    pos       = POS_HUNT;
    run_sum   = '0;
    esc_armed = 1'b0;
  endfunction

  function bit deframe(input logic [7:0] raw, output efp_result_t beat);
    logic [7:0] b;
    b    = raw;
    beat = '0;
    if (pos != POS_HUNT && b == START_MARK) restart();
    if (pos != POS_HUNT && b == ESC_MARK && !esc_armed) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    if (esc_armed) begin
      b         = b ^ ESC_FLIP;
      esc_armed = 1'b0;
    end
    if (pos >= HEAD_LEN) run_sum = run_sum + b;
    case (pos)
      POS_HUNT: begin
        if (b == START_MARK) pos = POS_LEN_HI;
        return 1'b0;
      end
      POS_LEN_HI: begin
        decl_len = {b, 8'h00};
        pos      = POS_LEN_LO;
        return 1'b0;
      end
      POS_LEN_LO: begin
        decl_len = {decl_len[15:8], b};
        pos      = POS_API;
        return 1'b0;
      end
      POS_API: begin
        cur_api = b;
        pos     = POS_DATA;
        return 1'b0;
      end
      default: ;
    endcase
    beat.api_id = cur_api;
    if (pos > MAX_FRAME) begin
      beat.kind         = KIND_END;
      beat.frame_length = FLEN_W'(MAX_FRAME - HEAD_LEN);
      beat.status       = ST_OVERFLOW;
      restart();
      return 1'b1;
    end
    if (pos == int'(decl_len) + HEAD_LEN) begin
      beat.kind         = KIND_END;
      beat.frame_length = FLEN_W'(pos - POS_DATA);
      beat.status       = (run_sum == SUM_GOOD) ? ST_OK : ST_CSUM;
      restart();
      return 1'b1;
    end
    beat.kind       = KIND_DATA;
    beat.data_byte  = b;
    beat.byte_index = 8'(pos - POS_DATA);
    pos++;
    return 1'b1;
  endfunction

  function void note_byte(input logic [7:0] raw);
    efp_result_t beat;
    if (deframe(raw, beat)) parsed_beats.push_back(beat);
  endfunction

  function int pending();
    return parsed_beats.size();
  endfunction

  task report(input string msg);
    errors++;
    if (errors <= 20) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_beat(input efp_result_t got);
    efp_result_t want;
    if (parsed_beats.size() == 0) begin
      report($sformatf("beat with nothing pending, kind %0d data %0h",
                       got.kind, got.data_byte));
      return;
    end
    want = parsed_beats.pop_front();
    cmp_field("kind", 16'(got.kind), 16'(want.kind));
    cmp_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
    cmp_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
    cmp_field("api_id", 16'(got.api_id), 16'(want.api_id));
    cmp_field("frame_length", 16'(got.frame_length), 16'(want.frame_length));
    cmp_field("status", 16'(got.status), 16'(want.status));
    if (want.kind == KIND_DATA) data_beats++;
    else if (want.status == ST_OK) ends_ok++;
    else if (want.status == ST_CSUM) ends_csum++;
    else ends_ovf++;
  endtask
endclass

module escaped_api_frame_parser_core_tb;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int ITEMS_TARGET = 1550;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_COMB} rx_mode_e;
  typedef enum int {CS_NONE, CS_GOOD, CS_BAD} csum_mode_e;

  localparam logic [7:0] DIRECTED [26] = '{
    ESC_MARK, 8'h33,
    START_MARK, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hFF, 8'h01,
    START_MARK, 8'h00, 8'h04, 8'h12, ESC_MARK,
    START_MARK, 8'h00, 8'h02, 8'h00, ESC_MARK, ESC_MARK, 8'h00,
    START_MARK, 8'h00, 8'h01, 8'h40, 8'hBF
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_kind;
  logic [7:0]        out_data_byte;
  logic [7:0]        out_byte_index;
  logic [7:0]        out_api_id;
  logic [FLEN_W-1:0] out_frame_length;
  logic [1:0]        out_status;

  frame_scoreboard sb = new();

  logic [7:0]  wire_q[$];
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned segments;
  rx_mode_e    rx_mode;
  int unsigned rx_left;
  int unsigned rx_phase;

  escaped_api_frame_parser_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_api_id       (out_api_id),
    .out_frame_length (out_frame_length),
    .out_status       (out_status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin : monitor
    efp_result_t beat;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        beat.kind         = out_kind;
        beat.data_byte    = out_data_byte;
        beat.byte_index   = out_byte_index;
        beat.api_id       = out_api_id;
        beat.frame_length = out_frame_length;
        beat.status       = out_status;
        sb.check_beat(beat);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_FREE, RX_COMB));
      rx_left = $urandom_range(32, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_phase % 7) >= 2;
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return START_MARK;
      1:       return ESC_MARK;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_esc(input logic [7:0] v, input int esc_pct);
    if (v == START_MARK || v == ESC_MARK ||
        ((v ^ ESC_FLIP) != START_MARK && $urandom_range(1, 100) <= esc_pct)) begin
      wire_q.push_back(ESC_MARK);
      wire_q.push_back(v ^ ESC_FLIP);
    end else begin
      wire_q.push_back(v);
    end
  endfunction

  function automatic void add_frame(input logic [15:0] len, input logic [7:0] api,
                                    input int ndata, input csum_mode_e cmode,
                                    input int esc_pct);
    logic [7:0] sum;
    logic [7:0] d;
    wire_q.push_back(START_MARK);
    put_esc(len[15:8], esc_pct);
    put_esc(len[7:0], esc_pct);
    put_esc(api, esc_pct);
    sum = api;
    repeat (ndata) begin
      d   = pick_byte();
      sum = sum + d;
      put_esc(d, esc_pct);
    end
    if (cmode == CS_GOOD) put_esc(SUM_GOOD - sum, esc_pct);
    else if (cmode == CS_BAD) put_esc(SUM_GOOD - sum + 8'($urandom_range(1, 255)), esc_pct);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid   <= 1'b0;
        in_rx_byte <= 8'($urandom);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_queued();
    while (wire_q.size() != 0) send_byte(wire_q.pop_front());
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int         r;
    int         flen;
    csum_mode_e cm;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    out_ready   = 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    cycle_count = 0;
    segments    = 0;
    rx_left     = 0;
    rx_phase    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) wire_q.push_back(DIRECTED[i]);
    send_queued();

    while (items_sent < ITEMS_TARGET) begin
      segments++;
      r  = $urandom_range(0, 99);
      cm = ($urandom_range(0, 99) < 85) ? CS_GOOD : CS_BAD;
      if (segments == 15) begin
        add_frame(16'h0000, pick_byte(), MAX_FRAME - 2, CS_NONE, 5);
      end else if (segments == 45) begin
        add_frame(16'(MAX_FRAME - HEAD_LEN), pick_byte(), MAX_FRAME - 4, cm, 5);
      end else if (segments == 75) begin
        add_frame({8'($urandom_range(1, 255)), 8'($urandom)}, pick_byte(),
                  MAX_FRAME - 2, CS_NONE, 5);
      end else if (r < 68) begin
        flen = $urandom_range(1, 12);
        add_frame(16'(flen), pick_byte(), flen - 1, cm, 8);
      end else if (r < 76) begin
        flen = $urandom_range(2, 12);
        add_frame(16'(flen), pick_byte(), $urandom_range(0, flen - 2), CS_NONE, 8);
      end else if (r < 80) begin
        wire_q.push_back(START_MARK);
        repeat ($urandom_range(0, 2)) wire_q.push_back(pick_byte());
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6)) wire_q.push_back(pick_byte());
      end else if (r < 96) begin
        flen = $urandom_range(13, 60);
        add_frame(16'(flen), pick_byte(), flen - 1, cm, 8);
      end else begin
        flen = $urandom_range(1, 12);
        add_frame(16'(flen), pick_byte(), flen - 1, cm, 60);
      end
      send_queued();
      if (segments == 30 || segments == 90) wait_drain();
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("drove %0d bytes in %0d random segments plus directed frames",
             items_sent, segments);
    $display("checked %0d data beats, %0d good ends, %0d checksum errors, %0d overflows",
             sb.data_beats, sb.ends_ok, sb.ends_csum, sb.ends_ovf);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/efp_pkg.sv
hw/rtl/efp_deframer.sv
hw/rtl/escaped_api_frame_parser_core.sv
sim/escaped_api_frame_parser_core_tb.sv
